// ===== sv/seven_segment_decimal_display_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Seven-segment display unit: assertion macros
// Concurrent assertion wrappers; defining ASSERT_OFF leaves them empty.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_DECIMAL_DISPLAY_UNIT_DEFINES_SVH
`define SEVEN_SEGMENT_DECIMAL_DISPLAY_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define SDD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define SDD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define SDD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SDD_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/sdd_pkg.sv =====
// ----------------------------------------------------------------------------
// sdd_pkg
// Shared constants, glyph table and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdd_pkg;

	localparam int DIGITS_DEF = 8;       // display digits
	localparam int DEC_DIGITS = 8;       // decimal digits kept from a value
	localparam int BIN_W      = 32;
	localparam int BCD_W      = 4 * DEC_DIGITS;
	localparam int CMD_W      = 2;
	localparam int POS_W      = 4;
	localparam int CNT_W      = 4;
	localparam int CODE_W     = 5;
	localparam int SEG_W      = 8;
	localparam int EN_W       = 8;
	localparam int STEP_W     = $clog2(BIN_W);
	localparam int DIG_W      = $clog2(DEC_DIGITS);

	localparam logic [CMD_W-1:0] CMD_SCAN     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WR_ZERO  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_WR_BLANK = 2'd2;

	localparam logic [CODE_W-1:0] BLANK_CODE = 5'd23;

	// controller -> datapath
	typedef struct packed {
		logic start;   // latch value, position, count
		logic blank;   // leading zeros become blank
		logic shift;   // one double-dabble step
		logic write;   // store one digit
		logic scan;    // load output register, advance scan
	} sdd_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic conv_last;  // final conversion step
		logic dig_last;   // final digit written
	} sdd_stat_t;

	// active-low glyphs, bit 0 = segment a
	function automatic logic [SEG_W-1:0] glyph(input logic [CODE_W-1:0] code);
		logic [SEG_W-1:0] seg;
		unique case (code)
			5'd0:    seg = 8'hC0;
			5'd1:    seg = 8'hF9;
			5'd2:    seg = 8'hA4;
			5'd3:    seg = 8'hB0;
			5'd4:    seg = 8'h99;
			5'd5:    seg = 8'h92;
			5'd6:    seg = 8'h82;
			5'd7:    seg = 8'hF8;
			5'd8:    seg = 8'h80;
			5'd9:    seg = 8'h90;
			5'd10:   seg = 8'h88;
			5'd11:   seg = 8'h83;
			5'd12:   seg = 8'hC6;
			5'd13:   seg = 8'hA1;
			5'd14:   seg = 8'h86;
			5'd15:   seg = 8'h8E;
			5'd16:   seg = 8'h89;
			5'd17:   seg = 8'hC7;
			5'd18:   seg = 8'hC8;
			5'd19:   seg = 8'h8C;
			5'd20:   seg = 8'hC1;
			5'd21:   seg = 8'hBF;
			5'd22:   seg = 8'h7F;
			5'd23:   seg = 8'hFF;
			default: seg = 8'hFF;
		endcase
		return seg;
	endfunction

endpackage

// ===== sv/seven_segment_decimal_display_unit.sv =====
// ----------------------------------------------------------------------------
// Timing: a scan tick request gives its result in the output register in the
//   cycle after acceptance; a write request holds the unit busy through the
//   32-step conversion loop and then one buffer store per digit (1..8 digits).
// Throughput: one scan tick per cycle while the unit is idle and the output
//   register is drained; writes bound by the 32-step double-dabble loop plus one buffer store per digit.
// Reset: asynchronous; buffer reads blank, scanning restarts at digit 1.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// seven_segment_decimal_display_unit
// Multiplexed common-anode seven-segment display controller for up to eight digits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "seven_segment_decimal_display_unit_defines.svh"

module seven_segment_decimal_display_unit import sdd_pkg::*; #(
	parameter int DIGITS = DIGITS_DEF   // 1..8 display digits
) (
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // command[1:0], position[5:2], digit_count[9:6],
	                               // value[41:10], zero fill[47:42]
	// result stream, one per scan tick
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // digit_enable[7:0], segments[15:8]
);

	// request fields
	logic [CMD_W-1:0] req_cmd;
	logic [POS_W-1:0] req_pos;
	logic [CNT_W-1:0] req_cnt;
	logic [BIN_W-1:0] req_value;

	assign req_cmd   = s_tdata[1:0];
	assign req_pos   = s_tdata[5:2];
	assign req_cnt   = s_tdata[9:6];
	assign req_value = s_tdata[41:10];

	sdd_cmd_t  ctrl_cmd;
	sdd_stat_t dp_stat;

	logic [EN_W-1:0]  digit_enable;
	logic [SEG_W-1:0] segments;

	// Controller: accepts requests only when idle. A scan tick waits only if
	// the output register is still full; writes run the conversion loop.
	sdd_ctrl #(
		.DIGITS(DIGITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(s_tvalid),
		.req_cmd  (req_cmd),
		.req_pos  (req_pos),
		.req_cnt  (req_cnt),
		.out_ready(m_tready),
		.stat     (dp_stat),
		.req_ready(s_tready),
		.out_valid(m_tvalid),
		.cmd      (ctrl_cmd)
	);

	// Datapath: 32-step binary to BCD (low eight decimal digits), then one
	// buffer store per digit, most significant first; glyph lookup on scan.
	sdd_dpath #(
		.DIGITS(DIGITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (ctrl_cmd),
		.req_pos     (req_pos),
		.req_cnt     (req_cnt),
		.req_value   (req_value),
		.stat        (dp_stat),
		.digit_enable(digit_enable),
		.segments    (segments)
	);

	assign m_tdata = {segments, digit_enable};

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	// exactly one digit lit on every offered result
	`SDD_ASSERT_IMP(a_en_onehot, clk, arst_n, m_tvalid, $onehot(m_tdata[7:0]))
	// no new request while converting or storing
	`SDD_ASSERT_IMP(a_busy_stall, clk, arst_n, ctrl_cmd.shift || ctrl_cmd.write, !s_tready)
	// conversion and store phases never overlap
	`SDD_ASSERT_IMP(a_phase_excl, clk, arst_n, ctrl_cmd.shift, !ctrl_cmd.write)
	// an accepted in-range write goes straight into the conversion loop
	`SDD_ASSERT_NXT(a_start_conv, clk, arst_n, ctrl_cmd.start, ctrl_cmd.shift)

endmodule

// ===== sv/sdd_ctrl.sv =====
// ----------------------------------------------------------------------------
// sdd_ctrl
// Request sequencer: scan ticks straight to the output register, writes through convert/store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdd_ctrl import sdd_pkg::*; #(
	parameter int DIGITS = DIGITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic [CMD_W-1:0] req_cmd,
	input  logic [POS_W-1:0] req_pos,
	input  logic [CNT_W-1:0] req_cnt,
	input  logic             out_ready,
	input  sdd_stat_t        stat,
	output logic             req_ready,
	output logic             out_valid,
	output sdd_cmd_t         cmd
);

	typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_WRITE} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   is_write;
	logic   wr_ok;

	assign is_write = (req_cmd == CMD_WR_ZERO) || (req_cmd == CMD_WR_BLANK);
	assign wr_ok    = (req_pos != '0) && (req_pos <= POS_W'(DIGITS)) && (req_cnt != '0);

	// a write never touches the output register, so it may pass a stalled result
	assign req_ready = (state_q == ST_IDLE) &&
		((req_cmd != CMD_SCAN) || !out_valid_q || out_ready);
	assign accept    = req_valid && req_ready;

	always_comb begin
		cmd.start = accept && is_write && wr_ok;
		cmd.blank = (req_cmd == CMD_WR_BLANK);
		cmd.shift = (state_q == ST_CONV);
		cmd.write = (state_q == ST_WRITE);
		cmd.scan  = accept && (req_cmd == CMD_SCAN);
	end

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.scan)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (cmd.start)
						state_q <= ST_CONV;
				end
				ST_CONV: begin
					if (stat.conv_last)
						state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if (stat.dig_last)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/sdd_dpath.sv =====
// ----------------------------------------------------------------------------
// sdd_dpath
// Double-dabble converter, symbol buffer, scan counter and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdd_dpath import sdd_pkg::*; #(
	parameter int DIGITS = DIGITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sdd_cmd_t         cmd,
	input  logic [POS_W-1:0] req_pos,
	input  logic [CNT_W-1:0] req_cnt,
	input  logic [BIN_W-1:0] req_value,
	output sdd_stat_t        stat,
	output logic [EN_W-1:0]  digit_enable,
	output logic [SEG_W-1:0] segments
);

	localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

	logic [BIN_W-1:0]  bin_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [BCD_W-1:0]  bcd_adj;
	logic [STEP_W-1:0] step_q;
	logic [DIG_W-1:0]  dig_q;
	logic [POS_W-1:0]  slot_q;
	logic              lead_q;
	logic [CNT_W-1:0]  cnt_sat;
	logic [3:0]        dec;
	logic              dec_blank;
	logic [CODE_W-1:0] wr_code;
	logic [CODE_W-1:0] sym_q [DIGITS];
	logic [IDX_W-1:0]  scan_q;
	logic [EN_W-1:0]   en_q;
	logic [SEG_W-1:0]  seg_q;

	// add 3 to every digit of 5 or more ahead of the shift
	always_comb begin
		for (int i = 0; i < DEC_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5)
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			else
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
		end
	end

	assign cnt_sat   = (req_cnt > CNT_W'(DEC_DIGITS)) ? CNT_W'(DEC_DIGITS) : req_cnt;
	assign dec       = bcd_q[4*dig_q +: 4];
	assign dec_blank = lead_q && (dec == 4'd0);
	assign wr_code   = dec_blank ? BLANK_CODE : {1'b0, dec};

	assign stat.conv_last = (step_q == STEP_W'(BIN_W - 1));
	assign stat.dig_last  = (dig_q == '0);

	// conversion registers: payload, no reset
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			bin_q  <= req_value;
			bcd_q  <= '0;
			step_q <= '0;
			dig_q  <= DIG_W'(cnt_sat - CNT_W'(1));
			slot_q <= req_pos - POS_W'(1);
			lead_q <= cmd.blank;
		end else if (cmd.shift) begin
			// carry out of the top digit is dropped: keeps value mod 10^8
			bcd_q  <= {bcd_adj[BCD_W-2:0], bin_q[BIN_W-1]};
			bin_q  <= {bin_q[BIN_W-2:0], 1'b0};
			step_q <= step_q + STEP_W'(1);
		end else if (cmd.write) begin
			lead_q <= dec_blank;
			slot_q <= slot_q + POS_W'(1);
			dig_q  <= dig_q - DIG_W'(1);
		end
	end

	// symbol buffer, blank after reset; digits past the last position dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGITS; i++)
				sym_q[i] <= BLANK_CODE;
		end else if (cmd.write && (slot_q < POS_W'(DIGITS))) begin
			sym_q[slot_q[IDX_W-1:0]] <= wr_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (cmd.scan) begin
			if (scan_q == IDX_W'(DIGITS - 1))
				scan_q <= '0;
			else
				scan_q <= scan_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			en_q  <= EN_W'(1) << scan_q;
			seg_q <= glyph(sym_q[scan_q]);
		end
	end

	assign digit_enable = en_q;
	assign segments     = seg_q;

endmodule

// ===== sim/seven_segment_decimal_display_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_decimal_display_unit_tb
// Self-checking bench for the display unit. Scan-tick and number-write
// requests are streamed in under random and directed traffic. A scoreboard
// keeps its own symbol buffer and scan position, predicts every digit-enable
// and segment byte, and compares each result as it is accepted.
// ----------------------------------------------------------------------------

module seven_segment_decimal_display_unit_tb;
	import sdd_pkg::*;

	// command code with no meaning to the unit
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam int CLK_HALF        = 6;
	localparam int RESET_CYCLES    = 6;
	localparam int GLYPH_COUNT     = 24;
	localparam int ITEMS_PER_PHASE = 125;
	localparam int HOLD_CYCLES     = 300;   // long receiver stall
	localparam int BURST_TICKS     = 24;    // ticks offered during that stall
	localparam int DRAIN_CYCLES    = 60;    // above the longest write latency
	localparam int TIMEOUT_NS      = 3_000_000;

	// packed MSB first, so segments lands in m_tdata[15:8]
	typedef struct packed {
		logic [SEG_W-1:0] segments;
		logic [EN_W-1:0]  digit_enable;
	} scan_result_t;

	// Mirror of the display state; predicts what each scan tick shows.
	class scan_predictor;
		logic [CODE_W-1:0] symbols [DIGITS_DEF];
		logic [2:0]        scan_pos;
		logic [SEG_W-1:0]  glyph_rom [GLYPH_COUNT];
		scan_result_t      expected_scans [$];
		int                errors;

		function new();
			glyph_rom = '{8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
			              8'h80, 8'h90, 8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E,
			              8'h89, 8'hC7, 8'hC8, 8'h8C, 8'hC1, 8'hBF, 8'h7F, 8'hFF};
			foreach (symbols[i])
				symbols[i] = BLANK_CODE;
			scan_pos = '0;
			errors   = 0;
		endfunction

		// one accepted request
		function void note_request(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
		                           logic [CNT_W-1:0] cnt, logic [BIN_W-1:0] value);
			scan_result_t      res;
			logic [3:0]        dec [DEC_DIGITS];
			logic [BIN_W-1:0]  rest;
			logic [CODE_W-1:0] code;
			int                n;
			int                slot;
			bit                leading;
			if (cmd == CMD_SCAN) begin
				res.digit_enable = '0;
				res.digit_enable[scan_pos] = 1'b1;
				code = symbols[scan_pos];
				res.segments = (code < GLYPH_COUNT) ? glyph_rom[code] : 8'hFF;
				expected_scans.push_back(res);
				scan_pos = scan_pos + 1'b1;   // wraps after digit 8
			end else if ((cmd == CMD_WR_ZERO || cmd == CMD_WR_BLANK) && pos != 0 &&
			             pos <= DIGITS_DEF && cnt != 0) begin
				n = (cnt > DEC_DIGITS) ? DEC_DIGITS : cnt;
				rest = value;
				for (int i = 0; i < DEC_DIGITS; i++) begin
					dec[i] = 4'(rest % 10);
					rest   = rest / 10;
				end
				leading = (cmd == CMD_WR_BLANK);
				slot = pos - 1;
				// most significant selected digit first, clipped at the right edge
				for (int k = n - 1; k >= 0; k--) begin
					code = CODE_W'(dec[k]);
					if (leading) begin
						if (code == 0)
							code = BLANK_CODE;
						else
							leading = 1'b0;
					end
					if (slot < DIGITS_DEF)
						symbols[slot] = code;
					slot++;
				end
			end
		endfunction

		// one accepted result against the oldest prediction
		function void check_scan(scan_result_t got);
			scan_result_t want;
			if (expected_scans.size() == 0) begin
				$display("%0t: unexpected scan result: expected none, actual %h",
				         $time, got);
				errors++;
				return;
			end
			want = expected_scans.pop_front();
			if (got.digit_enable !== want.digit_enable) begin
				$display("%0t: digit_enable mismatch: expected %h, actual %h",
				         $time, want.digit_enable, got.digit_enable);
				errors++;
			end
			if (got.segments !== want.segments) begin
				$display("%0t: segments mismatch: expected %h, actual %h",
				         $time, want.segments, got.segments);
				errors++;
			end
		endfunction
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata  = '0;   // command[1:0], position[5:2], digit_count[9:6],
	                              // value[41:10], zero fill[47:42]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;         // digit_enable[7:0], segments[15:8]

	int tx_idle_pct   = 0;
	int rx_idle_pct   = 0;
	bit hold_results  = 1'b0;

	scan_predictor predictor = new();

	seven_segment_decimal_display_unit #(
		.DIGITS(DIGITS_DEF)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Both handshakes are sampled at the edge, before any driven update lands.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			predictor.note_request(s_tdata[1:0], s_tdata[5:2], s_tdata[9:6],
			                       s_tdata[41:10]);
		if (arst_n && m_tvalid && m_tready)
			predictor.check_scan(m_tdata);
	end

	// Receiver: random back-pressure, plus one long hold on request.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_results) begin
				hold_results = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Drive one request and return at the edge where it is taken.
	// Valid stays high into the next call unless a gap is drawn.
	task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
	                            input logic [CNT_W-1:0] cnt, input logic [BIN_W-1:0] value);
		int gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, value, cnt, pos, cmd};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Values weighted towards short numbers so leading zeros are common.
	function automatic logic [BIN_W-1:0] random_value();
		logic [BIN_W-1:0] limit;
		limit = 1;
		case ($urandom_range(9))
			0: return '0;
			1, 2: return $urandom;
			// low six digits all zero: blank mode then shows nothing for counts up to six
			3: return $urandom_range(1, 99) * 1_000_000;
			default: begin
				repeat ($urandom_range(1, 8))
					limit = limit * 10;
				return $urandom % limit;
			end
		endcase
	endfunction

	// Mostly well-formed ticks and writes; the rest ignored or odd requests.
	// Only requests the unit acts on are counted.
	task automatic run_random(input int count);
		int               acted;
		int               pick;
		logic [CMD_W-1:0] cmd;
		logic [POS_W-1:0] pos;
		logic [CNT_W-1:0] cnt;
		acted = 0;
		while (acted < count) begin
			pick = $urandom_range(99);
			cmd  = $urandom_range(1) ? CMD_WR_BLANK : CMD_WR_ZERO;
			pos  = POS_W'($urandom_range(1, DIGITS_DEF));
			cnt  = CNT_W'($urandom_range(1, DEC_DIGITS));
			if (pick < 45) begin
				cmd = CMD_SCAN;
				pos = POS_W'($urandom_range(15));
				cnt = CNT_W'($urandom_range(15));
				acted++;
			end else if (pick < 88) begin
				acted++;
			end else begin
				case ($urandom_range(3))
					0: cmd = CMD_UNUSED;
					1: pos = $urandom_range(1) ? '0 : POS_W'($urandom_range(9, 15));
					2: cnt = '0;
					default: begin
						cnt = CNT_W'($urandom_range(9, 15));   // saturates to eight
						acted++;
					end
				endcase
			end
			send_request(cmd, pos, cnt, random_value());
		end
	endtask

	// Starts one edge on, so the request taken at the current edge is noted.
	task automatic wait_for_results();
		@(posedge clk);
		while (predictor.expected_scans.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, no idling on either side.
		send_request(CMD_SCAN, 0, 0, 0);                      // blank after reset
		send_request(CMD_WR_BLANK, 1, 8, 0);                  // zero: all blanks
		send_request(CMD_WR_ZERO, 1, 8, 32'hFFFF_FFFF);       // top digits dropped
		send_request(CMD_WR_ZERO, 5, 8, 12345678);            // clipped at the right
		send_request(CMD_WR_BLANK, 2, 6, 1200);               // leading blanks
		send_request(CMD_WR_ZERO, 0, 3, 999);                 // position zero, ignored
		send_request(CMD_WR_ZERO, 9, 3, 999);                 // past last digit, ignored
		send_request(CMD_WR_BLANK, 15, 15, 7);                // ignored as well
		send_request(CMD_WR_ZERO, 3, 0, 5);                   // no digits
		send_request(CMD_WR_BLANK, 8, 15, 87654321);          // saturated count, clipped
		send_request(CMD_UNUSED, 15, 15, 32'hFFFF_FFFF);      // unused code
		repeat (9) send_request(CMD_SCAN, 4'hF, 4'hF, 32'hFFFF_FFFF);   // full sweep
		send_request(CMD_WR_ZERO, 1, 8, 0);                   // zero padded zero
		repeat (3) send_request(CMD_SCAN, 0, 0, 0);

		// Sender sparse, receiver heavily stalled.
		tx_idle_pct = 29;
		rx_idle_pct = 68;
		run_random(ITEMS_PER_PHASE);

		// Receiver holds off while ticks keep coming, so the unit backs up.
		tx_idle_pct  = 0;
		hold_results = 1'b1;
		repeat (BURST_TICKS) send_request(CMD_SCAN, 0, 0, 0);

		// Sender pauses until every pending result is out.
		s_tvalid <= 1'b0;
		wait_for_results();

		// Roles swapped.
		tx_idle_pct = 68;
		rx_idle_pct = 29;
		run_random(ITEMS_PER_PHASE);

		// Back to back.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_random(ITEMS_PER_PHASE);

		s_tvalid <= 1'b0;
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (predictor.errors == 0 && predictor.expected_scans.size() == 0)
			$display("seven_segment_decimal_display_unit_tb passed");
		else
			$display("seven_segment_decimal_display_unit_tb failed");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#(TIMEOUT_NS);
		$display("seven_segment_decimal_display_unit_tb failed");
		$finish;
	end

endmodule
